// ----- sv/rasr_pkg.sv -----
package rasr_pkg;

  localparam int OperandWidth = 32;
  localparam int MagWidth     = 64;

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_SUB     = 2'd1,
    FUNC_ADD_INT = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_RED_N,
    ST_RED_D,
    ST_QUOT,
    ST_OUT
  } state_e;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_RED_N,
    DIV_RED_D,
    DIV_QUOT
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_a;
    logic     mul_b;
    logic     sum;
    logic     div_start;
    div_sel_e div_sel;
    logic     gcd_step;
    logic     red_n;
    logic     red_d;
    logic     quot;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic den_err;
    logic gcd_done;
    logic div_busy;
  } status_t;

endpackage

// ----- sv/rasr_divider.sv -----
module rasr_divider
  import rasr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MagWidth-1:0] dividend_i,
  input  logic [MagWidth-1:0] divisor_i,
  output logic                busy_o,
  output logic [MagWidth-1:0] quot_o,
  output logic [MagWidth-1:0] rem_o
);

  localparam int CntWidth = $clog2(MagWidth + 1);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [MagWidth-1:0] quot_q, quot_d;
  logic [MagWidth:0]   rem_q, rem_d;
  logic [MagWidth-1:0] dvs_q, dvs_d;
  logic [MagWidth:0]   shifted;

  // Restoring divider, one quotient bit per cycle.
  always_comb begin
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q[MagWidth-1:0], quot_q[MagWidth-1]};
    if (start_i) begin
      cnt_d  = CntWidth'(MagWidth);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = shifted - {1'b0, dvs_q};
        quot_d = {quot_q[MagWidth-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[MagWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q[MagWidth-1:0];

endmodule

// ----- sv/rasr_datapath.sv -----
module rasr_datapath
  import rasr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [1:0]              func_i,
  input  logic [OperandWidth-1:0] a_num_i,
  input  logic [OperandWidth-1:0] a_den_i,
  input  logic [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-1:0] b_den_i,
  output logic [63:0]             res_num_o,
  output logic [62:0]             res_den_o,
  output logic [63:0]             whole_part_o,
  output logic [62:0]             frac_rem_o,
  output logic                    is_integer_o,
  output logic                    den_error_o
);

  localparam int Ow = OperandWidth;

  logic                int_q;
  logic                sub_q;
  logic [Ow-1:0]       an_q, ad_q, bn_q, bd_q;
  logic [MagWidth-1:0] p1_q, p2_q;
  logic                p1n_q, p2n_q;
  logic [MagWidth-1:0] nmag_q, dmag_q;
  logic                nneg_q, dneg_q;
  logic [MagWidth-1:0] gx_q, gy_q;
  logic [MagWidth-1:0] div_a, div_b, div_q, div_r;
  logic                div_busy;
  logic                neg;
  logic [Ow-1:0]       mag_an, mag_ad, mag_bn, mag_bd;
  logic [MagWidth-1:0] mul_x, mul_y, mul_p;
  logic [MagWidth-1:0] sum_mag;
  logic                sum_neg;
  logic                t2_neg;
  logic [MagWidth-1:0] num_v, den_v;

  function automatic logic [Ow-1:0] mag(input logic [Ow-1:0] v);
    mag = v[Ow-1] ? (~v + 1'b1) : v;
  endfunction

  assign mag_an = mag(an_q);
  assign mag_ad = mag(ad_q);
  assign mag_bn = mag(bn_q);
  assign mag_bd = mag(bd_q);

  // One 32x32 unsigned multiplier shared by both cross products; the
  // denominator product has its own 32x32 multiplier.
  always_comb begin
    if (cmd_i.mul_a) begin
      mul_x = MagWidth'(mag_an);
      mul_y = int_q ? 64'd1 : MagWidth'(mag_bd);
    end else begin
      mul_x = MagWidth'(mag_bn);
      mul_y = MagWidth'(mag_ad);
    end
    mul_p = MagWidth'(mul_x[Ow-1:0] * mul_y[Ow-1:0]);
  end

  assign t2_neg = (bn_q[Ow-1] ^ ad_q[Ow-1]) ^ sub_q;

  always_comb begin
    if (p1n_q == p2n_q) begin
      sum_mag = p1_q + p2_q;
      sum_neg = p1n_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = p1n_q;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = p2n_q;
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_GCD:   begin div_a = gx_q;   div_b = gy_q;   end
      DIV_RED_N: begin div_a = nmag_q; div_b = gx_q;   end
      DIV_RED_D: begin div_a = dmag_q; div_b = gx_q;   end
      DIV_QUOT:  begin div_a = nmag_q; div_b = dmag_q; end
      default:   begin div_a = gx_q;   div_b = gy_q;   end
    endcase
  end

  rasr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      int_q <= func_i[1];
      sub_q <= func_i[0];
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
    end
    if (cmd_i.mul_a) begin
      p1_q  <= mul_p;
      p1n_q <= int_q ? an_q[Ow-1] : (an_q[Ow-1] ^ bd_q[Ow-1]);
      dmag_q <= MagWidth'(mag_ad);
      dneg_q <= ad_q[Ow-1];
    end
    if (cmd_i.mul_b) begin
      p2_q  <= mul_p;
      p2n_q <= int_q ? (bn_q[Ow-1] ^ ad_q[Ow-1]) : t2_neg;
      if (!int_q) begin
        dmag_q <= MagWidth'(mag_ad[Ow-1:0] * mag_bd[Ow-1:0]);
        dneg_q <= ad_q[Ow-1] ^ bd_q[Ow-1];
      end
    end
    if (cmd_i.sum) begin
      nmag_q <= sum_mag;
      nneg_q <= sum_neg;
      gx_q   <= sum_mag;
      gy_q   <= dmag_q;
    end
    if (cmd_i.gcd_step) begin
      gx_q <= gy_q;
      gy_q <= div_r;
    end
    if (cmd_i.red_n) nmag_q <= div_q;
    if (cmd_i.red_d) dmag_q <= div_q;
    if (cmd_i.quot) begin
      gy_q <= div_q;
      gx_q <= div_r;
    end
  end

  assign neg   = (nneg_q != dneg_q) && (nmag_q != '0);
  assign num_v = (!neg && nmag_q == 64'h8000_0000_0000_0000) ? 64'h7FFF_FFFF_FFFF_FFFF
               : (neg ? (~nmag_q + 1'b1) : nmag_q);
  assign den_v = neg ? (~gx_q + 1'b1) : gx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_error_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      den_error_o <= status_o.den_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (status_o.den_err) begin
        res_num_o    <= '0;
        res_den_o    <= '0;
        whole_part_o <= '0;
        frac_rem_o   <= '0;
        is_integer_o <= 1'b0;
      end else begin
        res_num_o    <= num_v;
        res_den_o    <= dmag_q[62:0];
        whole_part_o <= neg ? (~gy_q + 1'b1) : gy_q;
        frac_rem_o   <= den_v[62:0];
        is_integer_o <= (dmag_q == 64'd1);
      end
    end
  end

  assign status_o.den_err  = (ad_q == '0) || (!int_q && bd_q == '0);
  assign status_o.gcd_done = (gy_q == '0);
  assign status_o.div_busy = div_busy;

endmodule

// ----- sv/rasr_ctrl.sv -----
module rasr_ctrl
  import rasr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   started_q, started_d;

  always_comb begin
    state_d   = state_q;
    started_d = 1'b0;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_MUL_A;
      ST_MUL_A:   state_d = status_i.den_err ? ST_OUT : ST_MUL_B;
      ST_MUL_B:   state_d = ST_SUM;
      ST_SUM:     state_d = ST_GCD_CHK;
      ST_GCD_CHK: state_d = status_i.gcd_done ? ST_RED_N : ST_GCD_DIV;
      ST_GCD_DIV: begin
        started_d = 1'b1;
        if (started_q && !status_i.div_busy) state_d = ST_GCD_CHK;
      end
      ST_RED_N: begin
        started_d = 1'b1;
        if (started_q && !status_i.div_busy) state_d = ST_RED_D;
      end
      ST_RED_D: begin
        started_d = 1'b1;
        if (started_q && !status_i.div_busy) state_d = ST_QUOT;
      end
      ST_QUOT: begin
        started_d = 1'b1;
        if (started_q && !status_i.div_busy) state_d = ST_OUT;
      end
      ST_OUT:     if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_GCD;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL_A: cmd_o.mul_a = 1'b1;
      ST_MUL_B: cmd_o.mul_b = 1'b1;
      ST_SUM:   cmd_o.sum   = 1'b1;
      ST_GCD_DIV: begin
        cmd_o.div_sel   = DIV_GCD;
        cmd_o.div_start = !started_q;
        cmd_o.gcd_step  = started_q && !status_i.div_busy;
      end
      ST_RED_N: begin
        cmd_o.div_sel   = DIV_RED_N;
        cmd_o.div_start = !started_q;
        cmd_o.red_n     = started_q && !status_i.div_busy;
      end
      ST_RED_D: begin
        cmd_o.div_sel   = DIV_RED_D;
        cmd_o.div_start = !started_q;
        cmd_o.red_d     = started_q && !status_i.div_busy;
      end
      ST_QUOT: begin
        cmd_o.div_sel   = DIV_QUOT;
        cmd_o.div_start = !started_q;
        cmd_o.quot      = started_q && !status_i.div_busy;
      end
      ST_OUT:   cmd_o.out_load = !ov_q || out_ready_i;
      default:  cmd_o = '0;
    endcase
  end

  // Output register: hold until taken, load while the old one drains.
  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (cmd_o.out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ov_q      <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ov_q      <= ov_d;
      started_q <= started_d && (state_d == state_q);
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ----- sv/rational_add_sub_reduce_unit.sv -----
// Channel | Signals                      | Contents
// s_axis  | s_axis_tvalid/tready/tdata   | one operation: func, two fractions
// m_axis  | m_axis_tvalid/tready/tdata   | reduced fraction, whole part, remainder, flags
//
// An item goes through setup (load, cross products, sum), then Euclid steps (a divide
// plus a check each), divides for the numerator and denominator reduction and the quotient,
// and the output register load, all on one shared radix-2 64-bit divider.
// A zero denominator skips from the first multiply state straight to the output.
// Reset (rst_ni, async low) returns the controller to idle and drops m_axis_tvalid.
// The result stays in an output register while the next item is taken; a new result
// holds the controller until the old one is taken.
module rational_add_sub_reduce_unit
  import rasr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] func, [33:2] a_num, [65:34] a_den, [97:66] b_num, [129:98] b_den, rest 0
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] res_num, [126:64] res_den, [190:127] whole_part, [253:191] frac_rem,
  // [254] is_integer, [255] den_error
  output logic [255:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;
  logic [63:0] res_num, whole_part;
  logic [62:0] res_den, frac_rem;
  logic        is_integer, den_error;

  rasr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rasr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (s_axis_tdata[1:0]),
    .a_num_i      (s_axis_tdata[33:2]),
    .a_den_i      (s_axis_tdata[65:34]),
    .b_num_i      (s_axis_tdata[97:66]),
    .b_den_i      (s_axis_tdata[129:98]),
    .res_num_o    (res_num),
    .res_den_o    (res_den),
    .whole_part_o (whole_part),
    .frac_rem_o   (frac_rem),
    .is_integer_o (is_integer),
    .den_error_o  (den_error)
  );

  assign m_axis_tdata = {den_error, is_integer, frac_rem, whole_part, res_den, res_num};

endmodule

// ----- tb/rational_add_sub_reduce_unit_tb.sv -----
`timescale 1ns / 100ps

module rational_add_sub_reduce_unit_tb;
  import rasr_pkg::*;

  typedef struct packed {
    logic        den_error;
    logic        is_integer;
    logic [62:0] frac_rem;
    logic [63:0] whole_part;
    logic [62:0] res_den;
    logic [63:0] res_num;
  } rat_result_t;

  localparam longint unsigned CycleLimit = 64'd20000000;

  // One expected reduced fraction per accepted operation, in order.
  class rational_scoreboard;
    rat_result_t pending_q[$];
    int          errors;

    static function logic [63:0] magnitude(logic signed [63:0] x);
      return x[63] ? -x : x;
    endfunction

    static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    static function rat_result_t reduce_op(logic [135:0] data);
      rat_result_t       r;
      func_e             fn;
      logic signed [63:0] an, ad, bn, bd, t1, t2;
      logic [63:0]       m1, m2, nmag, dmag, g, q, rm;
      logic              n1, n2, nneg, dneg, neg;
      fn = func_e'(data[1:0]);
      an = {{32{data[33]}}, data[33:2]};
      ad = {{32{data[65]}}, data[65:34]};
      bn = {{32{data[97]}}, data[97:66]};
      bd = {{32{data[129]}}, data[129:98]};
      r = '0;
      if (ad == 0 || (!fn[1] && bd == 0)) begin
        r.den_error = 1'b1;
        return r;
      end
      t2 = bn * ad;
      if (fn[1]) begin
        t1 = an;
        dmag = magnitude(ad);
        dneg = ad < 0;
      end else begin
        t1 = an * bd;
        if (fn == FUNC_SUB) t2 = -t2;
        dmag = magnitude(ad) * magnitude(bd);
        dneg = (ad < 0) != (bd < 0);
      end
      m1 = magnitude(t1);
      m2 = magnitude(t2);
      n1 = t1 < 0;
      n2 = t2 < 0;
      if (n1 == n2) begin
        nmag = m1 + m2;
        nneg = n1;
      end else if (m1 >= m2) begin
        nmag = m1 - m2;
        nneg = n1;
      end else begin
        nmag = m2 - m1;
        nneg = n2;
      end
      g = gcd64(nmag, dmag);
      nmag = nmag / g;
      dmag = dmag / g;
      neg = (nneg != dneg) && nmag != 0;
      q = nmag / dmag;
      rm = nmag % dmag;
      if (!neg && nmag == 64'h8000_0000_0000_0000) r.res_num = 64'h7fff_ffff_ffff_ffff;
      else r.res_num = neg ? -nmag : nmag;
      r.res_den = dmag[62:0];
      r.whole_part = neg ? -q : q;
      rm = neg ? -rm : rm;
      r.frac_rem = rm[62:0];
      r.is_integer = dmag == 1;
      return r;
    endfunction

    function void note_operation(logic [135:0] data);
      pending_q.push_back(reduce_op(data));
    endfunction

    function void check_result(logic [255:0] data);
      rat_result_t got, exp_r;
      got = data;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.res_num !== exp_r.res_num)
        $display("%0t: res_num exp %0d got %0d", $time, $signed(exp_r.res_num),
                 $signed(got.res_num));
      if (got.res_den !== exp_r.res_den)
        $display("%0t: res_den exp %0d got %0d", $time, exp_r.res_den, got.res_den);
      if (got.whole_part !== exp_r.whole_part)
        $display("%0t: whole_part exp %0d got %0d", $time, $signed(exp_r.whole_part),
                 $signed(got.whole_part));
      if (got.frac_rem !== exp_r.frac_rem)
        $display("%0t: frac_rem exp %h got %h", $time, exp_r.frac_rem, got.frac_rem);
      if (got.is_integer !== exp_r.is_integer)
        $display("%0t: is_integer exp %b got %b", $time, exp_r.is_integer, got.is_integer);
      if (got.den_error !== exp_r.den_error)
        $display("%0t: den_error exp %b got %b", $time, exp_r.den_error, got.den_error);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [255:0] m_axis_tdata;

  rational_scoreboard fraction_sb;
  longint unsigned    cycle_count;
  logic               hold_results;

  rational_add_sub_reduce_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 20)) - 10);
      1: return 32'h8000_0000 | 32'($urandom_range(0, 3));
      2: return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [135:0] pack_op(logic [1:0] fn, logic [31:0] an,
                                           logic [31:0] ad, logic [31:0] bn,
                                           logic [31:0] bd);
    return {6'b0, bd, bn, ad, an, fn};
  endfunction

  // Offer one operation and hold it until the transaction completes.
  task automatic send_op(logic [135:0] data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    fraction_sb.note_operation(data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_random(int n);
    logic [31:0] ad, bd;
    for (int i = 0; i < n; i++) begin
      ad = rand_operand();
      bd = rand_operand();
      if ($urandom_range(0, 19) == 0) ad = '0;
      if ($urandom_range(0, 19) == 0) bd = '0;
      send_op(pack_op(2'($urandom_range(0, 3)), rand_operand(), ad, rand_operand(), bd));
    end
  endtask

  task automatic drain_wait();
    while (fraction_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern; a long hold-off is forced while hold_results is set.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) m_axis_tready <= 1'b0;
      else m_axis_tready <= (cycle_count[8:6] == 3'd5) ? ($urandom_range(0, 3) == 0)
                                                       : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) fraction_sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    fraction_sb   = new();
    cycle_count   = 0;
    hold_results  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_op(pack_op(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    send_op(pack_op(FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2));
    send_op(pack_op(FUNC_ADD_INT, -32'sd7, 32'd3, 32'd2, 32'd0));
    send_op(pack_op(FUNC_RSVD, 32'd5, -32'sd4, -32'sd3, 32'd9));
    send_op(pack_op(FUNC_ADD, 32'd3, 32'd0, 32'd1, 32'd1));
    send_op(pack_op(FUNC_SUB, 32'd3, 32'd4, 32'd1, 32'd0));
    send_op(pack_op(FUNC_ADD_INT, 32'd3, 32'd0, 32'd1, 32'd0));
    send_op(pack_op(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_op(pack_op(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_op(pack_op(FUNC_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_op(pack_op(FUNC_ADD_INT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0));
    send_op(pack_op(FUNC_ADD_INT, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'hffff_ffff));
    send_op(pack_op(FUNC_ADD, 32'd0, -32'sd5, 32'd0, 32'd7));
    send_op(pack_op(FUNC_SUB, -32'sd6, -32'sd4, 32'd9, 32'd6));
    send_op(pack_op(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_op(pack_op(FUNC_SUB, 32'd7, 32'd13, 32'd7, 32'd13));

    // Long receiver hold-off while operations keep coming.
    fork
      begin
        hold_results = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_results = 1'b0;
      end
      send_random(8);
    join
    drain_wait();

    for (int burst = 0; burst < 72; burst++) begin
      send_random($urandom_range(1, 15));
      if (burst == 36) drain_wait();
      else repeat ($urandom_range(0, 300)) @(posedge clk_i);
    end

    drain_wait();
    repeat (600) @(posedge clk_i);
    if (fraction_sb.errors == 0 && fraction_sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- rational_add_sub_reduce_unit.f -----
sv/rasr_pkg.sv
sv/rasr_divider.sv
sv/rasr_datapath.sv
sv/rasr_ctrl.sv
sv/rational_add_sub_reduce_unit.sv
tb/rational_add_sub_reduce_unit_tb.sv
